// ===== design/lse_pkg.sv =====
// ============================================================================
// lse_pkg
// Shared constants, codes and types of the LED strip effect engine.
// ============================================================================
package lse_pkg;

    localparam int MAX_LEDS = 64;
    localparam int IDX_W    = $clog2(MAX_LEDS);
    localparam int CNT_W    = 7;
    localparam int CH_W     = 8;
    localparam int RGB_W    = 3 * CH_W;

    localparam logic [2:0] MODE_PLAIN  = 3'd0;
    localparam logic [2:0] MODE_BLINK  = 3'd1;
    localparam logic [2:0] MODE_ROT_L  = 3'd2;
    localparam logic [2:0] MODE_ROT_R  = 3'd3;
    localparam logic [2:0] MODE_FADE   = 3'd4;

    localparam logic [1:0] KIND_WRITE_ONE = 2'd0;
    localparam logic [1:0] KIND_WRITE_ALL = 2'd1;
    localparam logic [1:0] KIND_TICK      = 2'd2;

    localparam logic [1:0] REG_LED_COUNT   = 2'd0;
    localparam logic [1:0] REG_EFFECT_MODE = 2'd1;
    localparam logic [1:0] REG_FADE_STEPS  = 2'd2;

    typedef struct packed {
        logic [RGB_W-1:0] pri;
        logic [RGB_W-1:0] sec;
    } colour_pair_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_REDUCE,
        S_FRAME,
        S_DRAIN,
        S_FREAD,
        S_FWAIT,
        S_FCALC
    } state_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_MUL,
        F_DONE
    } fade_state_t;

endpackage

// ===== design/led_strip_effect_engine.sv =====
// ============================================================================
// led_strip_effect_engine
// LED strip effect engine: colour stores, effect sequencing and pixel output.
// ============================================================================
// Usage. An item is taken at a rising edge with start high and busy low. A
// single LED write completes at that edge. A write of all LEDs sweeps the
// store one entry per cycle and keeps busy high until the sweep ends. An
// update tick emits one frame of led_count pixels, at most 64; each pixel is
// one beat on the result ports, marked by pixel_valid for exactly one cycle,
// with frame_last set on the final beat. The receiver cannot stall the block.
// Plain and blink frames give one pixel a cycle, set by the single read port
// of the store. Rotate frames also give one pixel a cycle, once repeated
// subtraction of the LED count has brought a stale phase below the count.
// Fade frames take one pixel at a time through the 8-step bit-serial divider
// in the fade unit. The first plain or blink pixel passes the store read
// register and the output beat register after the tick is taken, and the
// last pixel may still be shown in the first cycle that busy is low again.
// Configuration goes through its own valid/ready channel, which is always
// ready. Reset clears the colour stores to black (through per-entry valid
// bits, so no clearing pass is needed), the phase and the toggle, and sets
// led_count to 64, effect_mode to plain and fade_steps to 1.
// ============================================================================
module led_strip_effect_engine
    import lse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       kind,
    input  logic [7:0]       led_index,
    input  logic [CH_W-1:0]  primary_red,
    input  logic [CH_W-1:0]  primary_green,
    input  logic [CH_W-1:0]  primary_blue,
    input  logic [CH_W-1:0]  secondary_red,
    input  logic [CH_W-1:0]  secondary_green,
    input  logic [CH_W-1:0]  secondary_blue,
    output logic             pixel_valid,
    output logic [IDX_W-1:0] pixel_index,
    output logic [CH_W-1:0]  out_green,
    output logic [CH_W-1:0]  out_red,
    output logic [CH_W-1:0]  out_blue,
    output logic             frame_last,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] led_count_reg;
    logic [2:0]       mode_reg;
    logic [CH_W-1:0]  fade_steps_reg;
    logic [CH_W-1:0]  phase_reg;
    logic             tog_reg;
    logic [IDX_W-1:0] pix_reg;
    colour_pair_t     fill_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_last_reg;
    logic             pixel_valid_reg;
    logic [IDX_W-1:0] pixel_index_reg;
    logic [RGB_W-1:0] px_reg;
    logic             frame_last_reg;

    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] last_idx;
    logic             pix_last;
    logic [CH_W-1:0]  fs_eff;
    logic             accept;
    logic             cfg_wr;
    logic             is_blink;
    logic             is_rot;
    logic             is_fade;
    colour_pair_t     in_pair;
    logic [CNT_W-1:0] rot_sum;
    logic [CNT_W-1:0] rot_wrap;
    logic             we;
    logic [IDX_W-1:0] waddr;
    colour_pair_t     wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
    colour_pair_t     rdata;
    logic             fade_start;
    logic             fade_done;
    logic [RGB_W-1:0] fade_px;
    logic [CH_W:0]    fade_up;
    logic [CH_W-1:0]  rot_left;

    // Counts above the store depth behave as the full store.
    assign count    = (led_count_reg > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : led_count_reg;
    assign last_idx = count - CNT_W'(1);
    assign pix_last = ({1'b0, pix_reg} == last_idx);
    assign fs_eff   = (fade_steps_reg == '0) ? CH_W'(1) : fade_steps_reg;
    assign accept   = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_wr   = cfg_valid && cfg_ready;
    assign is_blink = (mode_reg == MODE_BLINK);
    assign is_rot   = (mode_reg == MODE_ROT_L) || (mode_reg == MODE_ROT_R);
    assign is_fade  = (mode_reg == MODE_FADE);
    assign in_pair  = '{pri: {primary_red, primary_green, primary_blue},
                        sec: {secondary_red, secondary_green, secondary_blue}};

    // Rotated address: both terms are below the count, so one conditional
    // subtraction finishes the modulo.
    assign rot_sum  = {1'b0, pix_reg} + phase_reg[CNT_W-1:0];
    assign rot_wrap = (rot_sum >= count) ? (rot_sum - count) : rot_sum;

    assign we    = (state_reg == S_FILL) ||
                   (accept && kind == KIND_WRITE_ONE && led_index < {1'b0, count});
    assign waddr = (state_reg == S_FILL) ? pix_reg : led_index[IDX_W-1:0];
    assign wdata = (state_reg == S_FILL) ? fill_reg : in_pair;
    assign re    = (state_reg == S_FRAME) || (state_reg == S_FREAD);
    assign raddr = is_rot ? rot_wrap[IDX_W-1:0] : pix_reg;

    assign fade_up  = {1'b0, phase_reg} + 9'd1;
    assign rot_left = phase_reg + CH_W'(1);

    lse_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    lse_fade u_fade (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fade_start),
        .c1    (rdata.pri),
        .c2    (rdata.sec),
        .fs    (fs_eff),
        .phase (phase_reg),
        .done  (fade_done),
        .px    (fade_px)
    );

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && count != '0)
                begin
                    if (kind == KIND_WRITE_ALL)
                    begin
                        state_next = S_FILL;
                    end
                    else if (kind == KIND_TICK)
                    begin
                        priority if (is_fade)
                            state_next = S_FREAD;
                        else if (is_rot)
                            state_next = S_REDUCE;
                        else
                            state_next = S_FRAME;
                    end
                end
            end
            S_FILL:   if (pix_last) state_next = S_IDLE;
            S_REDUCE: if (phase_reg < {1'b0, count}) state_next = S_FRAME;
            S_FRAME:  if (pix_last) state_next = S_DRAIN;
            S_DRAIN:  state_next = S_IDLE;
            S_FREAD:  state_next = S_FWAIT;
            S_FWAIT:  state_next = S_FCALC;
            S_FCALC:  if (fade_done) state_next = pix_last ? S_IDLE : S_FREAD;
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        busy       = (state_reg != S_IDLE);
        fade_start = (state_reg == S_FWAIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            led_count_reg   <= CNT_W'(MAX_LEDS);
            mode_reg        <= MODE_PLAIN;
            fade_steps_reg  <= CH_W'(1);
            phase_reg       <= '0;
            tog_reg         <= 1'b0;
            pix_reg         <= '0;
            rd_vld_reg      <= 1'b0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                pix_reg <= '0;
            end
            else if (state_reg == S_FILL || state_reg == S_FRAME ||
                     (state_reg == S_FCALC && fade_done))
            begin
                pix_reg <= pix_reg + IDX_W'(1);
            end

            // Configuration registers, phase and toggle. Writing the mode or step count restarts the effect.
            if (cfg_wr && cfg_index == REG_LED_COUNT)
            begin
                led_count_reg <= cfg_data[CNT_W-1:0];
            end
            else if (cfg_wr && cfg_index == REG_EFFECT_MODE)
            begin
                mode_reg  <= cfg_data[2:0];
                phase_reg <= '0;
                tog_reg   <= (cfg_data[2:0] == MODE_FADE);
            end
            else if (cfg_wr && cfg_index == REG_FADE_STEPS)
            begin
                fade_steps_reg <= cfg_data;
                phase_reg      <= '0;
                tog_reg        <= is_fade;
            end
            else if (accept && kind == KIND_TICK && count != '0 && is_fade)
            begin
                // The fade phase bounces between zero and the step count less one.
                if (tog_reg)
                begin
                    if (fade_up >= {1'b0, fs_eff})
                    begin
                        tog_reg <= 1'b0;
                    end
                    else
                    begin
                        phase_reg <= fade_up[CH_W-1:0];
                    end
                end
                else if (phase_reg <= CH_W'(1))
                begin
                    phase_reg <= '0;
                    tog_reg   <= 1'b1;
                end
                else
                begin
                    phase_reg <= phase_reg - CH_W'(1);
                end
            end
            else if (state_reg == S_REDUCE && phase_reg >= {1'b0, count})
            begin
                phase_reg <= phase_reg - {1'b0, count};
            end
            else if (state_reg == S_DRAIN)
            begin
                if (is_blink)
                begin
                    tog_reg <= !tog_reg;
                end
                else if (mode_reg == MODE_ROT_L)
                begin
                    phase_reg <= (rot_left >= {1'b0, count}) ? '0 : rot_left;
                end
                else if (mode_reg == MODE_ROT_R)
                begin
                    phase_reg <= (phase_reg == '0) ? {1'b0, last_idx} : phase_reg - CH_W'(1);
                end
            end

            rd_vld_reg      <= (state_reg == S_FRAME);
            pixel_valid_reg <= rd_vld_reg || (state_reg == S_FCALC && fade_done);
        end
    end

    // Read pipeline tag and output beat registers. The colour pair of a write
    // of all LEDs is held here while the store is swept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fill_reg <= in_pair;
        end
        rd_idx_reg  <= pix_reg;
        rd_last_reg <= pix_last;
        if (rd_vld_reg)
        begin
            pixel_index_reg <= rd_idx_reg;
            frame_last_reg  <= rd_last_reg;
            px_reg          <= (is_blink && tog_reg) ? rdata.sec : rdata.pri;
        end
        else
        begin
            pixel_index_reg <= pix_reg;
            frame_last_reg  <= pix_last;
            px_reg          <= fade_px;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign out_red     = px_reg[2*CH_W +: CH_W];
    assign out_green   = px_reg[CH_W +: CH_W];
    assign out_blue    = px_reg[0 +: CH_W];
    assign frame_last  = frame_last_reg;

    // The beat after the last pixel of a frame never carries a pixel.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid_reg && frame_last_reg |=> !pixel_valid_reg)
        else $error("pixel beat directly after the last pixel of a frame");

    // The fade unit finishes only while the sequencer waits for it.
    a_fade_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        fade_done |-> state_reg == S_FCALC)
        else $error("fade unit finished outside a fade pixel");

    // A pixel beat always comes out of frame work in the cycle before.
    a_beat_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid_reg |-> $past(state_reg) != S_IDLE)
        else $error("pixel beat without frame work");

    // Reads and writes of the store never coincide.
    a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        re |-> !we)
        else $error("store read and written in the same cycle");

endmodule

// ===== design/lse_store.sv =====
// ============================================================================
// lse_store
// Colour store: one entry per LED holding the primary and secondary colour,
// with a registered read port and per-entry valid bits cleared at reset.
// ============================================================================
module lse_store
    import lse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  colour_pair_t     wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output colour_pair_t     rdata
);

    colour_pair_t          mem_reg [MAX_LEDS];
    colour_pair_t          rdata_reg;
    logic [MAX_LEDS-1:0]   vld_reg;
    logic                  rvld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    // An entry never written reads as black.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvld_reg <= vld_reg[raddr];
            end
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule

// ===== design/lse_fade.sv =====
// ============================================================================
// lse_fade
// Fade pixel unit: per channel a bit-serial divide of the colour difference
// by the step count, a clamp, one multiply by the phase and a final subtract or add.
// ============================================================================
module lse_fade
    import lse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RGB_W-1:0] c1,
    input  logic [RGB_W-1:0] c2,
    input  logic [CH_W-1:0]  fs,
    input  logic [CH_W-1:0]  phase,
    output logic             done,
    output logic [RGB_W-1:0] px
);

    fade_state_t     state_reg;
    fade_state_t     state_next;
    logic [2:0]      cnt_reg;
    logic [CH_W-1:0] fs_reg;
    logic [CH_W-1:0] ph_reg;
    logic            div_en;
    logic            mul_en;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (start) state_next = F_DIV;
            F_DIV:  if (cnt_reg == 3'd7) state_next = F_MUL;
            F_MUL:  state_next = F_DONE;
            F_DONE: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        done   = (state_reg == F_DONE);
        div_en = (state_reg == F_DIV);
        mul_en = (state_reg == F_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_en)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == F_IDLE)
        begin
            fs_reg <= fs;
            ph_reg <= phase;
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic [CH_W-1:0]   a;
        logic [CH_W-1:0]   b;
        logic [CH_W-1:0]   c1_reg;
        logic              neg_reg;
        logic [CH_W-1:0]   div_reg;
        logic [CH_W-1:0]   rem_reg;
        logic [CH_W-1:0]   quo_reg;
        logic [CH_W-1:0]   prod_reg;
        logic [CH_W:0]     rem_sh;
        logic              ge;
        logic [CH_W:0]     rem_sub;
        logic [CH_W-2:0]   q_cl;
        logic [2*CH_W-2:0] prod;

        assign a       = c1[CH_W*l +: CH_W];
        assign b       = c2[CH_W*l +: CH_W];
        assign rem_sh  = {rem_reg, div_reg[CH_W-1]};
        assign ge      = rem_sh >= {1'b0, fs_reg};
        assign rem_sub = rem_sh - {1'b0, fs_reg};
        // The step magnitude saturates at 127.
        assign q_cl    = quo_reg[CH_W-1] ? {(CH_W-1){1'b1}} : quo_reg[CH_W-2:0];
        assign prod    = ph_reg * q_cl;

        always_ff @(posedge clk)
        begin
            if (start && state_reg == F_IDLE)
            begin
                c1_reg  <= a;
                neg_reg <= (a < b);
                div_reg <= (a < b) ? (b - a) : (a - b);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            else if (div_en)
            begin
                rem_reg <= ge ? rem_sub[CH_W-1:0] : rem_sh[CH_W-1:0];
                quo_reg <= {quo_reg[CH_W-2:0], ge};
                div_reg <= {div_reg[CH_W-2:0], 1'b0};
            end
            if (mul_en)
            begin
                prod_reg <= prod[CH_W-1:0];
            end
        end

        // A negative step turns the subtraction into an addition.
        assign px[CH_W*l +: CH_W] = neg_reg ? (c1_reg + prod_reg) : (c1_reg - prod_reg);
    end

endmodule
